/* sv/osl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_pkg
// Shared types, token codes and defaults for the Oberon-style lexer.
// ----------------------------------------------------------------------------
package osl_pkg;

    localparam int MAX_IDENT_CHARS_DEF   = 31;
    localparam int MAX_NUMBER_DIGITS_DEF = 20;
    localparam int MAX_COMMENT_DEPTH_DEF = 255;
    localparam int QUEUE_DEPTH           = 4;

    // token kinds
    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_INT     = 5'd1;
    localparam logic [4:0] K_CHAR    = 5'd2;
    localparam logic [4:0] K_HASH    = 5'd3;
    localparam logic [4:0] K_AMP     = 5'd4;
    localparam logic [4:0] K_LPAREN  = 5'd5;
    localparam logic [4:0] K_RPAREN  = 5'd6;
    localparam logic [4:0] K_STAR    = 5'd7;
    localparam logic [4:0] K_PLUS    = 5'd8;
    localparam logic [4:0] K_COMMA   = 5'd9;
    localparam logic [4:0] K_MINUS   = 5'd10;
    localparam logic [4:0] K_DOT     = 5'd11;
    localparam logic [4:0] K_COLON   = 5'd12;
    localparam logic [4:0] K_BECOMES = 5'd13;
    localparam logic [4:0] K_SEMI    = 5'd14;
    localparam logic [4:0] K_LESS    = 5'd15;
    localparam logic [4:0] K_LEQ     = 5'd16;
    localparam logic [4:0] K_GREATER = 5'd17;
    localparam logic [4:0] K_GEQ     = 5'd18;
    localparam logic [4:0] K_EQUAL   = 5'd19;
    localparam logic [4:0] K_LBRAK   = 5'd20;
    localparam logic [4:0] K_RBRAK   = 5'd21;
    localparam logic [4:0] K_TILDE   = 5'd22;
    localparam logic [4:0] K_ERROR   = 5'd23;

    // error codes
    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_BAD_CHAR   = 3'd1;
    localparam logic [2:0] E_NUM_LONG   = 3'd2;
    localparam logic [2:0] E_IDENT_LONG = 3'd3;
    localparam logic [2:0] E_NO_SUFFIX  = 3'd4;
    localparam logic [2:0] E_EOF_COMM   = 3'd5;
    localparam logic [2:0] E_NEST_DEEP  = 3'd6;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_COLON, M_LESS, M_GREATER, M_PAREN, M_COMMENT
    } mode_t;

    typedef enum logic [1:0] {
        C_PLAIN, C_STAR, C_PAREN
    } csub_t;

    typedef enum logic [1:0] {
        CMD_TOKEN, CMD_CHAR, CMD_IDENT
    } cmd_op_t;

    // one queue entry from front to back
    typedef struct packed {
        cmd_op_t     op;
        logic [4:0]  kind;
        logic [63:0] value;
        logic [2:0]  code;
        logic [7:0]  ch;
        logic        first;
        logic        kw;
        logic [15:0] line;
        logic [15:0] column;
    } cmd_t;

endpackage

/* sv/oberon_style_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oberon_style_lexer
// Byte-serial Oberon-style scanner: front classifier, command queue, back end.
// ----------------------------------------------------------------------------
// A single-beat token is captured in byte_reg, queued, and leaves via the back
// end's output register. The front takes one byte per cycle while the queue is
// not full; a byte that ends one token and starts another is stepped again,
// as the front posts one command per step. Identifier runs play out by character.
// Reset clears all control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module oberon_style_lexer
    import osl_pkg::*;
#(
    parameter int MAX_IDENT_CHARS   = MAX_IDENT_CHARS_DEF,
    parameter int MAX_NUMBER_DIGITS = MAX_NUMBER_DIGITS_DEF,
    parameter int MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         source_byte,
    input  logic               end_of_input,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         token_kind,
    output logic signed [63:0] number_value,
    output logic [7:0]         text_char,
    output logic               run_last,
    output logic               keyword_candidate,
    output logic [2:0]         error_code,
    output logic [15:0]        token_line,
    output logic [15:0]        token_column
);

    logic push, pop, q_full, q_not_empty;
    cmd_t push_cmd, head_cmd;

    // scanner front
    osl_front #(
        .MAX_IDENT_CHARS  (MAX_IDENT_CHARS),
        .MAX_NUMBER_DIGITS(MAX_NUMBER_DIGITS),
        .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .end_of_input(end_of_input),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // command queue
    osl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .not_empty(q_not_empty),
        .head_cmd (head_cmd)
    );

    // result back end
    osl_back #(
        .MAX_IDENT_CHARS(MAX_IDENT_CHARS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_not_empty      (q_not_empty),
        .head_cmd         (head_cmd),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .token_kind       (token_kind),
        .number_value     (number_value),
        .text_char        (text_char),
        .run_last         (run_last),
        .keyword_candidate(keyword_candidate),
        .error_code       (error_code),
        .token_line       (token_line),
        .token_column     (token_column)
    );

endmodule

/* sv/osl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_queue
// Small command queue between the scanner front and the result back end.
// ----------------------------------------------------------------------------
module osl_queue
    import osl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* sv/osl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_front
// Scanner front: takes source bytes, tracks position and token state,
// and posts at most one command per working cycle into the queue.
// ----------------------------------------------------------------------------
module osl_front
    import osl_pkg::*;
#(
    parameter int MAX_IDENT_CHARS   = MAX_IDENT_CHARS_DEF,
    parameter int MAX_NUMBER_DIGITS = MAX_NUMBER_DIGITS_DEF,
    parameter int MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] source_byte,
    input  logic       end_of_input,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int LW = $clog2(MAX_IDENT_CHARS + 1);

    mode_t       mode_reg, mode_next;
    csub_t       csub_reg, csub_next;
    logic        have_reg, have_next;
    logic        phase_reg, phase_next;
    logic [7:0]  byte_reg;
    logic        eof_reg;
    logic [63:0] dec_reg, dec_next;
    logic [63:0] hex_reg, hex_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        saw_hex_reg, saw_hex_next;
    logic [LW-1:0] len_reg, len_next;
    logic        upper_reg, upper_next;
    logic [7:0]  depth_reg, depth_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] sline_reg, sline_next;
    logic [15:0] scol_reg, scol_next;

    logic        step, accept, done, do_start;
    logic        is_dig, is_hexl, is_up, is_let, id_ch, num_ch;
    logic [3:0]  dval;
    logic        len_room, cnt_room, depth_full;

    // byte classes
    always_comb
    begin
        is_dig     = (byte_reg >= "0") && (byte_reg <= "9");
        is_hexl    = (byte_reg >= "A") && (byte_reg <= "F");
        is_up      = (byte_reg >= "A") && (byte_reg <= "Z");
        is_let     = is_up || ((byte_reg >= "a") && (byte_reg <= "z"));
        id_ch      = is_let || is_dig;
        num_ch     = is_dig || is_hexl;
        dval       = is_hexl ? (byte_reg[3:0] + 4'd9) : byte_reg[3:0];
        len_room   = (len_reg < LW'(MAX_IDENT_CHARS));
        cnt_room   = (cnt_reg < 5'(MAX_NUMBER_DIGITS));
        depth_full = (depth_reg >= 8'(MAX_COMMENT_DEPTH));
    end

    assign step     = have_reg && !q_full;
    assign do_start = phase_reg || (mode_reg == M_IDLE);
    assign in_stall = have_reg && !done;
    assign accept   = in_valid && !in_stall;

    // next scan mode
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            if (eof_reg)
            begin
                mode_next = M_IDLE;
            end
            else if (do_start)
            begin
                priority if (byte_reg <= 8'd32) mode_next = M_IDLE;
                else if (is_dig)                mode_next = M_NUMBER;
                else if (is_let)                mode_next = M_IDENT;
                else if (byte_reg == "(")       mode_next = M_PAREN;
                else if (byte_reg == ":")       mode_next = M_COLON;
                else if (byte_reg == "<")       mode_next = M_LESS;
                else if (byte_reg == ">")       mode_next = M_GREATER;
                else                            mode_next = M_IDLE;
            end
            else
            begin
                unique case (mode_reg)
                    M_IDENT:  mode_next = (id_ch && len_room) ? M_IDENT : M_IDLE;
                    M_NUMBER: mode_next = (num_ch && cnt_room) ? M_NUMBER : M_IDLE;
                    M_PAREN:  mode_next = (byte_reg == "*") ? M_COMMENT : M_IDLE;
                    M_COMMENT:
                        mode_next = (csub_reg == C_STAR && byte_reg == ")" &&
                                     depth_reg <= 8'd1) ? M_IDLE : M_COMMENT;
                    default:  mode_next = M_IDLE;
                endcase
            end
        end
    end

    // datapath, commands and position
    always_comb
    begin
        csub_next    = csub_reg;
        phase_next   = phase_reg;
        dec_next     = dec_reg;
        hex_next     = hex_reg;
        cnt_next     = cnt_reg;
        saw_hex_next = saw_hex_reg;
        len_next     = len_reg;
        upper_next   = upper_reg;
        depth_next   = depth_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        sline_next   = sline_reg;
        scol_next    = scol_reg;
        done         = 1'b0;
        push         = 1'b0;
        push_cmd     = '{op: CMD_TOKEN, kind: K_ERROR, value: '0, code: E_NONE,
                         ch: '0, first: 1'b0, kw: 1'b0, line: sline_reg,
                         column: scol_reg};
        if (step)
        begin
            done = 1'b1;
            if (eof_reg)
            begin
                // flush pending token, rewind position
                push = 1'b1;
                unique case (mode_reg)
                    M_IDENT:
                    begin
                        push_cmd.op = CMD_IDENT;
                        push_cmd.kw = upper_reg && (32'(len_reg) < 32'd10);
                    end
                    M_NUMBER:
                    begin
                        if (saw_hex_reg) push_cmd.code = E_NO_SUFFIX;
                        else
                        begin
                            push_cmd.kind  = K_INT;
                            push_cmd.value = dec_reg;
                        end
                    end
                    M_COLON:   push_cmd.kind = K_COLON;
                    M_LESS:    push_cmd.kind = K_LESS;
                    M_GREATER: push_cmd.kind = K_GREATER;
                    M_PAREN:   push_cmd.kind = K_LPAREN;
                    M_COMMENT: push_cmd.code = E_EOF_COMM;
                    default:   push = 1'b0;
                endcase
                depth_next = '0;
                csub_next  = C_PLAIN;
                line_next  = 16'd1;
                col_next   = 16'd1;
                phase_next = 1'b0;
            end
            else
            begin
                if (do_start)
                begin
                    // first byte of a token
                    phase_next = 1'b0;
                    push_cmd.line   = line_reg;
                    push_cmd.column = col_reg;
                    if (byte_reg > 8'd32)
                    begin
                        sline_next = line_reg;
                        scol_next  = col_reg;
                        push = 1'b1;
                        priority if (is_dig)
                        begin
                            push         = 1'b0;
                            dec_next     = {60'd0, dval};
                            hex_next     = {60'd0, dval};
                            cnt_next     = 5'd1;
                            saw_hex_next = 1'b0;
                        end
                        else if (is_let)
                        begin
                            push_cmd.op    = CMD_CHAR;
                            push_cmd.ch    = byte_reg;
                            push_cmd.first = 1'b1;
                            len_next       = LW'(1);
                            upper_next     = is_up;
                        end
                        else
                        begin
                            unique case (byte_reg)
                                "#": push_cmd.kind = K_HASH;
                                "&": push_cmd.kind = K_AMP;
                                ")": push_cmd.kind = K_RPAREN;
                                "*": push_cmd.kind = K_STAR;
                                "+": push_cmd.kind = K_PLUS;
                                ",": push_cmd.kind = K_COMMA;
                                "-": push_cmd.kind = K_MINUS;
                                ".": push_cmd.kind = K_DOT;
                                ";": push_cmd.kind = K_SEMI;
                                "=": push_cmd.kind = K_EQUAL;
                                "[": push_cmd.kind = K_LBRAK;
                                "]": push_cmd.kind = K_RBRAK;
                                "~": push_cmd.kind = K_TILDE;
                                "(", ":", "<", ">": push = 1'b0;
                                default: push_cmd.code = E_BAD_CHAR;
                            endcase
                        end
                    end
                end
                else
                begin
                    // byte inside a pending token
                    unique case (mode_reg)
                        M_IDENT:
                        begin
                            push = 1'b1;
                            if (id_ch)
                            begin
                                if (len_room)
                                begin
                                    push_cmd.op = CMD_CHAR;
                                    push_cmd.ch = byte_reg;
                                    len_next    = len_reg + LW'(1);
                                    upper_next  = upper_reg && is_up;
                                end
                                else push_cmd.code = E_IDENT_LONG;
                            end
                            else
                            begin
                                push_cmd.op = CMD_IDENT;
                                push_cmd.kw = upper_reg && (32'(len_reg) < 32'd10);
                                done        = 1'b0;
                            end
                        end
                        M_NUMBER:
                        begin
                            push = 1'b1;
                            if (num_ch)
                            begin
                                if (cnt_room)
                                begin
                                    push     = 1'b0;
                                    dec_next = (dec_reg << 3) + (dec_reg << 1) +
                                               {60'd0, dval};
                                    hex_next = (hex_reg << 4) | {60'd0, dval};
                                    cnt_next = cnt_reg + 5'd1;
                                    saw_hex_next = saw_hex_reg || is_hexl;
                                end
                                else push_cmd.code = E_NUM_LONG;
                            end
                            else if (byte_reg == "H")
                            begin
                                push_cmd.kind  = K_INT;
                                push_cmd.value = hex_reg;
                            end
                            else if (byte_reg == "X")
                            begin
                                push_cmd.kind  = K_CHAR;
                                push_cmd.value = hex_reg;
                            end
                            else
                            begin
                                done = 1'b0;
                                if (saw_hex_reg) push_cmd.code = E_NO_SUFFIX;
                                else
                                begin
                                    push_cmd.kind  = K_INT;
                                    push_cmd.value = dec_reg;
                                end
                            end
                        end
                        M_COLON, M_LESS, M_GREATER:
                        begin
                            push = 1'b1;
                            push_cmd.kind = (mode_reg == M_COLON) ? K_COLON :
                                            (mode_reg == M_LESS) ? K_LESS : K_GREATER;
                            if (byte_reg == "=") push_cmd.kind = push_cmd.kind + 5'd1;
                            else done = 1'b0;
                        end
                        M_PAREN:
                        begin
                            if (byte_reg == "*")
                            begin
                                depth_next = 8'd1;
                                csub_next  = C_PLAIN;
                            end
                            else
                            begin
                                push          = 1'b1;
                                push_cmd.kind = K_LPAREN;
                                done          = 1'b0;
                            end
                        end
                        default:
                        begin
                            // comment body
                            if (csub_reg == C_STAR && byte_reg == ")")
                            begin
                                if (depth_reg != 8'd0) depth_next = depth_reg - 8'd1;
                                csub_next = C_PLAIN;
                            end
                            else if (csub_reg == C_PAREN && byte_reg == "*")
                            begin
                                if (depth_full)
                                begin
                                    push            = 1'b1;
                                    push_cmd.code   = E_NEST_DEEP;
                                    push_cmd.line   = line_reg;
                                    push_cmd.column = (col_reg > 16'd1) ?
                                                      col_reg - 16'd1 : 16'd1;
                                end
                                else depth_next = depth_reg + 8'd1;
                                csub_next = C_PLAIN;
                            end
                            else if (byte_reg == "*") csub_next = C_STAR;
                            else if (byte_reg == "(") csub_next = C_PAREN;
                            else csub_next = C_PLAIN;
                        end
                    endcase
                    if (!done) phase_next = 1'b1;
                end
                // advance position once the byte is finished
                if (done)
                begin
                    if (byte_reg == 8'd10)
                    begin
                        if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
                        col_next = 16'd1;
                    end
                    else if (col_reg != 16'hFFFF) col_next = col_reg + 16'd1;
                end
            end
        end
        have_next = accept ? 1'b1 : (done ? 1'b0 : have_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            csub_reg    <= C_PLAIN;
            have_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            dec_reg     <= '0;
            hex_reg     <= '0;
            cnt_reg     <= '0;
            saw_hex_reg <= 1'b0;
            len_reg     <= '0;
            upper_reg   <= 1'b1;
            depth_reg   <= '0;
            line_reg    <= 16'd1;
            col_reg     <= 16'd1;
            sline_reg   <= 16'd1;
            scol_reg    <= 16'd1;
        end
        else
        begin
            mode_reg    <= mode_next;
            csub_reg    <= csub_next;
            have_reg    <= have_next;
            phase_reg   <= phase_next;
            dec_reg     <= dec_next;
            hex_reg     <= hex_next;
            cnt_reg     <= cnt_next;
            saw_hex_reg <= saw_hex_next;
            len_reg     <= len_next;
            upper_reg   <= upper_next;
            depth_reg   <= depth_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            sline_reg   <= sline_next;
            scol_reg    <= scol_next;
        end
    end

    // captured beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= source_byte;
            eof_reg  <= end_of_input;
        end
    end

endmodule

/* sv/osl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osl_back
// Result back end: holds the identifier buffer, plays out identifier runs
// one character per beat and forwards single tokens through an output register.
// ----------------------------------------------------------------------------
module osl_back
    import osl_pkg::*;
#(
    parameter int MAX_IDENT_CHARS = MAX_IDENT_CHARS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  cmd_t               head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         token_kind,
    output logic signed [63:0] number_value,
    output logic [7:0]         text_char,
    output logic               run_last,
    output logic               keyword_candidate,
    output logic [2:0]         error_code,
    output logic [15:0]        token_line,
    output logic [15:0]        token_column
);

    localparam int LW = $clog2(MAX_IDENT_CHARS + 1);
    localparam int IW = (MAX_IDENT_CHARS > 1) ? $clog2(MAX_IDENT_CHARS) : 1;

    logic [7:0]    ibuf [MAX_IDENT_CHARS];
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          run_reg, run_next;
    logic          kw_reg;
    logic [15:0]   rline_reg, rcol_reg;
    logic          ov_reg, ov_next;
    cmd_t          o_reg, o_next;
    logic          slot_free, run_end, wr_en, start_run;
    logic [LW-1:0] wr_pos;

    assign slot_free = !ov_reg || !out_stall;
    assign run_end   = (idx_reg + LW'(1)) == len_reg;
    assign pop       = slot_free && !run_reg && q_not_empty;
    assign wr_en     = pop && (head_cmd.op == CMD_CHAR);
    assign start_run = pop && (head_cmd.op == CMD_IDENT);
    assign wr_pos    = head_cmd.first ? '0 : len_reg;

    // result selection
    always_comb
    begin
        ov_next  = slot_free ? 1'b0 : ov_reg;
        o_next   = o_reg;
        idx_next = idx_reg;
        run_next = run_reg;
        len_next = len_reg;
        if (slot_free && run_reg)
        begin
            ov_next  = 1'b1;
            o_next   = '{op: CMD_TOKEN, kind: K_IDENT, value: '0, code: E_NONE,
                         ch: ibuf[idx_reg[IW-1:0]], first: run_end, kw: kw_reg,
                         line: rline_reg, column: rcol_reg};
            idx_next = idx_reg + LW'(1);
            run_next = !run_end;
        end
        else if (pop)
        begin
            unique case (head_cmd.op)
                CMD_TOKEN:
                begin
                    ov_next       = 1'b1;
                    o_next        = head_cmd;
                    o_next.ch     = '0;
                    o_next.first  = 1'b1;
                    o_next.kw     = 1'b0;
                    if (head_cmd.kind != K_ERROR) o_next.code = E_NONE;
                end
                CMD_CHAR:
                    len_next = wr_pos + LW'(1);
                default:
                begin
                    idx_next = '0;
                    run_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            run_reg <= 1'b0;
            idx_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            ov_reg  <= ov_next;
            run_reg <= run_next;
            idx_reg <= idx_next;
            len_reg <= len_next;
        end
    end

    // payload registers and identifier buffer
    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
        if (start_run)
        begin
            kw_reg    <= head_cmd.kw;
            rline_reg <= head_cmd.line;
            rcol_reg  <= head_cmd.column;
        end
        if (wr_en)
        begin
            ibuf[wr_pos[IW-1:0]] <= head_cmd.ch;
        end
    end

    assign out_valid         = ov_reg;
    assign token_kind        = o_reg.kind;
    assign number_value      = o_reg.value;
    assign text_char         = o_reg.ch;
    assign run_last          = o_reg.first;
    assign keyword_candidate = o_reg.kw;
    assign error_code        = o_reg.code;
    assign token_line        = o_reg.line;
    assign token_column      = o_reg.column;

`ifndef SYNTHESIS
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (len_reg != '0)) else $error("identifier run with empty buffer");
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (idx_reg < len_reg)) else $error("run index past length");
    a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !pop) else $error("queue popped during identifier run");
`endif

endmodule
